// File: sv/xor_trie_bounded_count_defines.svh
// assertion macros for the bounded-xor counting trie
// used by the port checker; needs a clock named i_clk and a reset named i_rst_n
`ifndef XOR_TRIE_BOUNDED_COUNT_DEFINES_SVH
`define XOR_TRIE_BOUNDED_COUNT_DEFINES_SVH

// same-cycle implication
`define XTBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XTBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/xtbc_pkg.sv
// shared types, constants and helpers of the bounded-xor counting trie
// no dependencies
`default_nettype none

package xtbc_pkg;

    localparam int KEY_BITS   = 22;
    localparam int NODE_COUNT = 65536;
    localparam int KEY_W      = KEY_BITS;
    localparam int CNT_BITS   = 24;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int FREE_BITS  = NODE_BITS + 1;
    localparam int LVL_BITS   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;

    typedef logic [NODE_BITS-1:0] t_node_idx;
    typedef logic [FREE_BITS:0]   t_wide;

    typedef struct packed {
        t_node_idx           c0;
        t_node_idx           c1;
        logic [CNT_BITS-1:0] n0;
        logic [CNT_BITS-1:0] n1;
    } t_node;

    typedef struct packed {
        logic      en;
        t_node_idx addr;
        t_node     data;
    } t_wr_req;

    function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                    input logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
    endfunction

    function automatic logic get_bit(input logic [KEY_W-1:0] v,
                                     input logic [LVL_BITS-1:0] i);
        logic [KEY_W-1:0] s;
        s = v >> i;
        return s[0];
    endfunction

    function automatic t_node set_child(input t_node nd, input logic b,
                                        input t_node_idx c,
                                        input logic [CNT_BITS-1:0] n);
        t_node r;
        r = nd;
        if (b) begin
            r.c1 = c;
            r.n1 = n;
        end else begin
            r.c0 = c;
            r.n0 = n;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/xtbc_node_ram.sv
// node store: child indexes and child pass counts of every non-root node
// depends on xtbc_pkg; one write port, one registered read port
`default_nettype none

module xtbc_node_ram
    import xtbc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_wr_req   i_wr,
    input  wire t_node_idx i_raddr,
    output t_node          o_rdata
);

    t_node r_mem [NODE_COUNT];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/xor_trie_bounded_count.sv
// query: one node read per level on the walk from accepted start to the result strobe
// insert: a probe walk comes first when under KEY_BITS nodes remain
// one request at a time; busy stays high until the result strobe, which cannot be stalled
// synchronous reset: root, threshold cleared, free pointer to 1; entries at/above the free
// pointer are never read, so the node store needs no clearing pass and is usable at once
`default_nettype none

module xor_trie_bounded_count
    import xtbc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_operation,
    input  wire logic [KEY_W-1:0]    i_key,
    output logic                     o_valid,
    output logic [CNT_BITS-1:0]      o_match_count,
    output logic                     o_store_full,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_ALLOC = 2'd3;

    localparam logic [LVL_BITS-1:0] LVL_TOP = LVL_BITS'(KEY_BITS - 1);

    logic [1:0]           r_state, n_state;
    logic                 r_op, n_op;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [LVL_BITS-1:0]  r_lvl, n_lvl;
    logic                 r_at_root, n_at_root;
    t_node_idx            r_cur, n_cur;
    logic [CNT_BITS-1:0]  r_sum, n_sum;
    logic [FREE_BITS-1:0] r_nf, n_nf;
    logic [KEY_W-1:0]     r_thr;
    t_node                r_root, n_root;
    logic                 r_valid, n_valid;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic                 r_full, n_full;

    t_wr_req   wr;
    t_node_idx raddr;
    t_node     rdata;
    t_node     cur;

    logic                bit_k, bit_t, bit_x;
    t_node_idx           c_same, c_next, new_c;
    logic [CNT_BITS-1:0] n_same, n_next, new_n, sum1;
    logic                cfg_wr;

    xtbc_node_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(r_thr) : 32'd0;

    assign cur    = r_at_root ? r_root : rdata;
    assign bit_k  = get_bit(r_key, r_lvl);
    assign bit_t  = get_bit(r_thr, r_lvl);
    assign bit_x  = bit_k ^ bit_t;
    assign c_same = bit_k ? cur.c1 : cur.c0;
    assign n_same = bit_k ? cur.n1 : cur.n0;
    assign c_next = bit_x ? cur.c1 : cur.c0;
    assign n_next = bit_x ? cur.n1 : cur.n0;
    assign new_c  = (c_same != '0) ? c_same : r_nf[NODE_BITS-1:0];
    assign new_n  = (c_same != '0) ? sat_add(n_same, CNT_ONE) : CNT_ONE;
    assign sum1   = sat_add(r_sum, (bit_t && c_same != '0) ? n_same : '0);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_lvl     = r_lvl;
        n_at_root = r_at_root;
        n_cur     = r_cur;
        n_sum     = r_sum;
        n_nf      = r_nf;
        n_root    = r_root;
        n_valid   = 1'b0;
        n_count   = r_count;
        n_full    = r_full;
        wr        = '0;
        raddr     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = i_operation;
                    n_key     = i_key;
                    n_lvl     = LVL_TOP;
                    n_at_root = 1'b1;
                    n_sum     = '0;
                    if (i_operation == OP_QUERY ||
                        (t_wide'(r_nf) + t_wide'(KEY_BITS)) <= t_wide'(NODE_COUNT)) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (c_same == '0 || r_lvl == '0) begin
                    if (c_same == '0 &&
                        (t_wide'(r_nf) + t_wide'(r_lvl) + t_wide'(1)) > t_wide'(NODE_COUNT))
                    begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_count = '0;
                        n_full  = 1'b1;
                    end else begin
                        n_state   = S_WALK;
                        n_lvl     = LVL_TOP;
                        n_at_root = 1'b1;
                    end
                end else begin
                    raddr     = c_same;
                    n_cur     = c_same;
                    n_at_root = 1'b0;
                    n_lvl     = r_lvl - LVL_BITS'(1);
                end
            end
            S_WALK: begin
                if (r_op == OP_QUERY) begin
                    if (c_next == '0) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_count = sum1;
                        n_full  = 1'b0;
                    end else if (r_lvl == '0) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_count = sat_add(sum1, n_next);
                        n_full  = 1'b0;
                    end else begin
                        raddr     = c_next;
                        n_cur     = c_next;
                        n_at_root = 1'b0;
                        n_sum     = sum1;
                        n_lvl     = r_lvl - LVL_BITS'(1);
                    end
                end else begin
                    if (r_at_root) begin
                        n_root = set_child(cur, bit_k, new_c, new_n);
                    end else begin
                        wr.en   = 1'b1;
                        wr.addr = r_cur;
                        wr.data = set_child(cur, bit_k, new_c, new_n);
                    end
                    if (c_same == '0) begin
                        n_nf = r_nf + FREE_BITS'(1);
                    end
                    if (r_lvl == '0) begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_count = '0;
                        n_full  = 1'b0;
                    end else if (c_same != '0) begin
                        raddr     = c_same;
                        n_cur     = c_same;
                        n_at_root = 1'b0;
                        n_lvl     = r_lvl - LVL_BITS'(1);
                    end else begin
                        n_state = S_ALLOC;
                        n_lvl   = r_lvl - LVL_BITS'(1);
                    end
                end
            end
            S_ALLOC: begin
                // fresh chain: node nf-1 points at node nf
                wr.en   = 1'b1;
                wr.addr = NODE_BITS'(r_nf - FREE_BITS'(1));
                wr.data = set_child('0, bit_k, r_nf[NODE_BITS-1:0], CNT_ONE);
                n_nf    = r_nf + FREE_BITS'(1);
                if (r_lvl == '0) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_count = '0;
                    n_full  = 1'b0;
                end else begin
                    n_lvl = r_lvl - LVL_BITS'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nf    <= FREE_BITS'(1);
            r_root  <= '0;
            r_thr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nf    <= n_nf;
            r_root  <= n_root;
            r_valid <= n_valid;
            if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
                r_thr <= pwdata[KEY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_lvl     <= n_lvl;
        r_at_root <= n_at_root;
        r_cur     <= n_cur;
        r_sum     <= n_sum;
        r_count   <= n_count;
        r_full    <= n_full;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_match_count = r_count;
    assign o_store_full  = r_full;

endmodule

`default_nettype wire

// File: sv/xtbc_checker.sv
// port-level checks of the bounded-xor counting trie, bound to the top level
// depends on xtbc_pkg and xor_trie_bounded_count_defines.svh
`default_nettype none

`include "xor_trie_bounded_count_defines.svh"

module xtbc_checker
    import xtbc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire logic [CNT_BITS-1:0] o_match_count,
    input wire logic                o_store_full
);

    `XTBC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `XTBC_ASSERT_NOW(a_result_idle, o_valid, !busy, "result shown while still busy")
    `XTBC_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `XTBC_ASSERT_NOW(a_full_no_count, o_valid && o_store_full, o_match_count == '0, "full with count")

endmodule

bind xor_trie_bounded_count xtbc_checker u_xtbc_checker (.*);

`default_nettype wire
